// ===== hw/rtl/asz_pkg.sv =====
// ----------------------------------------------------------------------------
// asz_pkg: shared types and constants of the atlas size search unit
// Field widths, register map, height limit and sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package asz_pkg;

	// payload field widths
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned CELL_SIZE_W  = 11;
	localparam int unsigned CELL_SPACE_W = 8;
	localparam int unsigned PITCH_W      = 12;
	localparam int unsigned AW_W         = 14;
	localparam int unsigned AH_W         = 28;

	// tallest height that still counts as a fit
	localparam logic [AH_W-1:0] HEIGHT_LIMIT = 28'd134217728;

	// configuration port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic        REG_CELL_SIZE  = 1'b0;
	localparam logic        REG_CELL_SPACE = 1'b1;
	localparam logic [CELL_SIZE_W-1:0]  CELL_SIZE_RST  = 11'd16;
	localparam logic [CELL_SPACE_W-1:0] CELL_SPACE_RST = 8'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_RDIV,
		ST_RMUL,
		ST_HINIT,
		ST_HSRCH,
		ST_CMUL,
		ST_EVAL,
		ST_ADV,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/asz_div_step.sv =====
// ----------------------------------------------------------------------------
// asz_div_step: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and returns the quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module asz_div_step #(
	parameter int unsigned RB = 17
) (
	input  wire logic [RB-1:0] rem_in,
	input  wire logic          bit_in,
	input  wire logic [RB-1:0] divisor,
	output logic      [RB-1:0] rem_out,
	output logic               q_bit
);

	logic [RB:0] trial;
	logic [RB:0] diff;

	assign trial   = {rem_in, bit_in};
	assign diff    = trial - {1'b0, divisor};
	assign q_bit   = (trial >= {1'b0, divisor});
	assign rem_out = q_bit ? diff[RB-1:0] : trial[RB-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/atlas_size_search_unit.sv =====
// ----------------------------------------------------------------------------
// atlas_size_search_unit: power-of-two atlas width and height search
// Widens the atlas until a width holds one pitch, then for each candidate width
//   divides for the rows, multiplies them by the pitch and doubles the height up
//   to that need; a width whose needed height passes the limit is skipped. The rows
//   divider runs DB restoring steps (17 at WIDTH_CAP 8192). All steps share one
//   restoring divide step and one multiplier. Zero pitch goes straight to the
//   result; one request in flight at a time.
// Reset: asynchronous, clears the sequencer and loads the default registers.
// ----------------------------------------------------------------------------
`default_nettype none

module atlas_size_search_unit
	import asz_pkg::*;
#(
	parameter int unsigned WIDTH_CAP = 8192
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// requests
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [15:0]        s_tdata,   // [15:0] cell_count
	// results
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [47:0]        m_tdata,   // [13:0] atlas_width, [41:14] atlas_height
	output logic                    m_tuser    // [0] found
);

	localparam int unsigned WB = $clog2(WIDTH_CAP) + 2;
	localparam int unsigned CB = $clog2(WIDTH_CAP) + 1;
	localparam int unsigned DB = ((CB > COUNT_W) ? CB : COUNT_W) + 1;
	localparam int unsigned RB = (CB > PITCH_W) ? CB : PITCH_W;
	localparam int unsigned PB = DB + AH_W;
	localparam int unsigned SB = ((WB > AH_W) ? WB : AH_W) + 1;
	localparam int unsigned NB = $clog2(DB);

	state_t state_q, state_d;

	logic [CELL_SIZE_W-1:0]  cell_size_q;
	logic [CELL_SPACE_W-1:0] cell_space_q;
	logic [PITCH_W-1:0]      pitch_in;
	logic                    cfg_wr;

	logic [PITCH_W-1:0] pitch_q;
	logic [COUNT_W-1:0] count_q;
	logic [WB-1:0]      w_q;
	logic [CB-1:0]      cols_q;
	logic [PITCH_W-1:0] colr_q;
	logic [DB-1:0]      dvd_q;
	logic [RB-1:0]      rem_q;
	logic [DB-1:0]      rows_q;
	logic [NB-1:0]      cnt_q;
	logic [PB-1:0]      prod_q;
	logic [AH_W-1:0]    h_q;
	logic [AH_W-1:0]    hq_q;
	logic [PITCH_W-1:0] hr_q;
	logic               have_q;
	logic [WB-1:0]      best_w_q;
	logic [AH_W-1:0]    best_h_q;
	logic [PB-1:0]      least_waste_q;

	logic [RB-1:0]   step_rem;
	logic            step_bit;
	logic [RB-1:0]   step_div;
	logic [RB-1:0]   step_rem_out;
	logic            step_q;
	logic [DB-1:0]   mul_a;
	logic [AH_W-1:0] mul_b;
	logic [PB-1:0]   mul_p;

	logic            w_over;
	logic            h_short;
	logic            fits;
	logic [PB-1:0]   loss;
	logic [SB-1:0]   sum_new;
	logic [SB-1:0]   sum_best;
	logic [WB+AW_W-1:0] w_ext;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= CELL_SIZE_RST;
			cell_space_q <= CELL_SPACE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_W-1])
				REG_CELL_SIZE:  cell_size_q  <= pwdata[CELL_SIZE_W-1:0];
				REG_CELL_SPACE: cell_space_q <= pwdata[CELL_SPACE_W-1:0];
				default:        cell_size_q  <= cell_size_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[PADDR_W-1])
			REG_CELL_SIZE:  prdata = PDATA_W'(cell_size_q);
			REG_CELL_SPACE: prdata = PDATA_W'(cell_space_q);
			default:        prdata = '0;
		endcase
	end

	assign pitch_in = PITCH_W'(cell_size_q) + PITCH_W'({cell_space_q, 1'b0});

	// ------------------------------------------------------------------------
	// shared divide step and multiplier
	// ------------------------------------------------------------------------
	asz_div_step #(
		.RB (RB)
	) u_step (
		.rem_in  (step_rem),
		.bit_in  (step_bit),
		.divisor (step_div),
		.rem_out (step_rem_out),
		.q_bit   (step_q)
	);

	assign mul_a = (state_q == ST_RMUL) ? rows_q : DB'(cols_q);
	assign mul_b = (state_q == ST_RMUL) ? AH_W'(pitch_q) : hq_q;
	assign mul_p = mul_a * mul_b;

	assign w_over   = (w_q > WB'(WIDTH_CAP));
	assign h_short  = (PB'(h_q) < prod_q);
	assign fits     = (prod_q >= PB'(count_q));
	assign loss     = prod_q - PB'(count_q);
	assign sum_new  = SB'(w_q) + SB'(h_q);
	assign sum_best = SB'(best_w_q) + SB'(best_h_q);

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_rem = '0;
		step_bit = 1'b0;
		step_div = RB'(pitch_q);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (pitch_in == '0) ? ST_OUT : ST_INIT;
				end
			end
			ST_INIT: begin
				step_bit = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				step_rem = RB'(colr_q);
				if (w_over) begin
					state_d = ST_OUT;
				end else if (cols_q != '0) begin
					state_d = ST_RDIV;
				end
			end
			ST_RDIV: begin
				step_rem = rem_q;
				step_bit = dvd_q[DB-1];
				step_div = RB'(cols_q);
				if (cnt_q == NB'(DB - 1)) begin
					state_d = ST_RMUL;
				end
			end
			ST_RMUL: begin
				state_d = ST_HINIT;
			end
			ST_HINIT: begin
				step_bit = 1'b1;
				state_d  = (prod_q > PB'(HEIGHT_LIMIT)) ? ST_ADV : ST_HSRCH;
			end
			ST_HSRCH: begin
				step_rem = RB'(hr_q);
				if (!h_short) begin
					state_d = ST_CMUL;
				end
			end
			ST_CMUL: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_ADV;
			end
			ST_ADV: begin
				step_rem = RB'(colr_q);
				state_d  = ST_SCAN;
			end
			ST_OUT: begin
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					count_q       <= s_tdata;
					pitch_q       <= pitch_in;
					w_q           <= WB'(1);
					cols_q        <= '0;
					colr_q        <= '0;
					have_q        <= 1'b0;
					best_w_q      <= '0;
					best_h_q      <= '0;
					least_waste_q <= '0;
				end
			end
			ST_INIT: begin
				cols_q <= {cols_q[CB-2:0], step_q};
				colr_q <= step_rem_out[PITCH_W-1:0];
			end
			ST_SCAN: begin
				if (!w_over && cols_q == '0) begin
					// widen until one pitch fits
					w_q    <= {w_q[WB-2:0], 1'b0};
					cols_q <= {cols_q[CB-2:0], step_q};
					colr_q <= step_rem_out[PITCH_W-1:0];
				end else begin
					// rows = ceil(count / cols)
					dvd_q <= DB'(count_q) + DB'(cols_q) - DB'(1);
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_RDIV: begin
				rem_q  <= step_rem_out;
				rows_q <= {rows_q[DB-2:0], step_q};
				dvd_q  <= {dvd_q[DB-2:0], 1'b0};
				cnt_q  <= cnt_q + NB'(1);
			end
			ST_RMUL: begin
				prod_q <= mul_p;
			end
			ST_HINIT: begin
				h_q  <= AH_W'(1);
				hq_q <= AH_W'(step_q);
				hr_q <= step_rem_out[PITCH_W-1:0];
			end
			ST_HSRCH: begin
				if (h_short) begin
					// double the height and track height / pitch alongside
					h_q  <= {h_q[AH_W-2:0], 1'b0};
					hq_q <= {hq_q[AH_W-2:0], step_q};
					hr_q <= step_rem_out[PITCH_W-1:0];
				end
			end
			ST_CMUL: begin
				prod_q <= mul_p;
			end
			ST_EVAL: begin
				if (fits) begin
					if (!have_q || loss < least_waste_q) begin
						have_q        <= 1'b1;
						best_w_q      <= w_q;
						best_h_q      <= h_q;
						least_waste_q <= loss;
					end else if (loss == least_waste_q && sum_new < sum_best) begin
						best_w_q <= w_q;
						best_h_q <= h_q;
					end
				end
			end
			ST_ADV: begin
				w_q    <= {w_q[WB-2:0], 1'b0};
				cols_q <= {cols_q[CB-2:0], step_q};
				colr_q <= step_rem_out[PITCH_W-1:0];
			end
			ST_OUT: begin
				have_q <= have_q;
			end
			default: begin
				have_q <= have_q;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// handshake and result
	// ------------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);

	assign w_ext   = {{AW_W{1'b0}}, best_w_q};
	assign m_tuser = have_q;
	assign m_tdata = {{(48 - AW_W - AH_W){1'b0}}, best_h_q, w_ext[AW_W-1:0]};

endmodule

`default_nettype wire

// ===== hw/rtl/asz_checker.sv =====
// ----------------------------------------------------------------------------
// asz_checker: port-level checks of the atlas size search unit
// Watches the request and result channels and flags ordering or payload
// violations.
// ----------------------------------------------------------------------------
`default_nettype none

module asz_checker
	import asz_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no fit means zero sizes
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 48'd0)
		else $error("sizes nonzero without a fit");

	// a chosen height is a single power of two
	a_height_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $onehot(m_tdata[AW_W+AH_W-1:AW_W]))
		else $error("height not a power of two");

	// drop ready while a result is pending
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while result pending");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after a request");

endmodule

bind atlas_size_search_unit asz_checker u_asz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
